// ===== sv/sqlck_pkg.sv =====
package sqlck_pkg;

  localparam int unsigned KIND_W = 5;
  localparam int unsigned POS_W  = 16;

  localparam logic [KIND_W-1:0] K_END      = 5'd0;
  localparam logic [KIND_W-1:0] K_ID       = 5'd1;
  localparam logic [KIND_W-1:0] K_STR      = 5'd2;
  localparam logic [KIND_W-1:0] K_NUM      = 5'd3;
  localparam logic [KIND_W-1:0] K_EQ       = 5'd4;
  localparam logic [KIND_W-1:0] K_GTE      = 5'd9;
  localparam logic [KIND_W-1:0] K_CREATE   = 5'd10;
  localparam logic [KIND_W-1:0] K_TABLE    = 5'd11;
  localparam logic [KIND_W-1:0] K_INSERT   = 5'd12;
  localparam logic [KIND_W-1:0] K_INTO     = 5'd13;
  localparam logic [KIND_W-1:0] K_VALUES   = 5'd14;
  localparam logic [KIND_W-1:0] K_SELECT   = 5'd15;
  localparam logic [KIND_W-1:0] K_FROM     = 5'd16;
  localparam logic [KIND_W-1:0] K_WHERE    = 5'd17;
  localparam logic [KIND_W-1:0] K_DELETE   = 5'd18;
  localparam logic [KIND_W-1:0] K_UPDATE   = 5'd19;
  localparam logic [KIND_W-1:0] K_SET      = 5'd20;
  localparam logic [KIND_W-1:0] K_BEGIN    = 5'd21;
  localparam logic [KIND_W-1:0] K_COMMIT   = 5'd22;
  localparam logic [KIND_W-1:0] K_ROLLBACK = 5'd23;
  localparam logic [KIND_W-1:0] K_PRIMARY  = 5'd24;
  localparam logic [KIND_W-1:0] K_KEY      = 5'd25;
  localparam logic [KIND_W-1:0] K_LP       = 5'd26;
  localparam logic [KIND_W-1:0] K_RP       = 5'd27;
  localparam logic [KIND_W-1:0] K_COMMA    = 5'd28;
  localparam logic [KIND_W-1:0] K_SEMI     = 5'd29;
  localparam logic [KIND_W-1:0] K_STAR     = 5'd30;

  localparam logic [3:0] R_SYNTAX    = 4'd0;
  localparam logic [3:0] R_TABLE     = 4'd1;
  localparam logic [3:0] R_DEF_COL   = 4'd2;
  localparam logic [3:0] R_TYPE      = 4'd3;
  localparam logic [3:0] R_KEY_MARK  = 4'd4;
  localparam logic [3:0] R_INS_VAL   = 4'd5;
  localparam logic [3:0] R_SEL_COL   = 4'd6;
  localparam logic [3:0] R_SEL_STAR  = 4'd7;
  localparam logic [3:0] R_SET_COL   = 4'd8;
  localparam logic [3:0] R_SET_VAL   = 4'd9;
  localparam logic [3:0] R_WHERE_COL = 4'd10;
  localparam logic [3:0] R_WHERE_OP  = 4'd11;
  localparam logic [3:0] R_WHERE_LIT = 4'd12;

  localparam logic [2:0] ST_CREATE   = 3'd0;
  localparam logic [2:0] ST_INSERT   = 3'd1;
  localparam logic [2:0] ST_SELECT   = 3'd2;
  localparam logic [2:0] ST_DELETE   = 3'd3;
  localparam logic [2:0] ST_UPDATE   = 3'd4;
  localparam logic [2:0] ST_BEGIN    = 3'd5;
  localparam logic [2:0] ST_COMMIT   = 3'd6;
  localparam logic [2:0] ST_ROLLBACK = 3'd7;

  localparam logic [2:0] E_STMT    = 3'd0;
  localparam logic [2:0] E_IDENT   = 3'd1;
  localparam logic [2:0] E_LITERAL = 3'd2;
  localparam logic [2:0] E_OPER    = 3'd3;
  localparam logic [2:0] E_TOKEN   = 3'd4;
  localparam logic [2:0] E_KEY_POS = 3'd5;

  typedef enum logic [5:0] {
    G_START        = 6'd0,
    G_SEMI         = 6'd1,
    G_C_TABLE      = 6'd2,
    G_C_NAME       = 6'd3,
    G_C_LP         = 6'd4,
    G_C_COL        = 6'd5,
    G_C_TYPE       = 6'd6,
    G_C_AFTER_TYPE = 6'd7,
    G_C_KEY        = 6'd8,
    G_C_AFTER_KEY  = 6'd9,
    G_C_RP_SEMI    = 6'd10,
    G_I_INTO       = 6'd11,
    G_I_NAME       = 6'd12,
    G_I_VALUES     = 6'd13,
    G_I_LP         = 6'd14,
    G_I_VAL        = 6'd15,
    G_I_AFTER      = 6'd16,
    G_S_FIRST      = 6'd17,
    G_S_AFTER_COL  = 6'd18,
    G_S_COL        = 6'd19,
    G_S_FROM       = 6'd20,
    G_S_TABLE      = 6'd21,
    G_W_OPT        = 6'd22,
    G_W_COL        = 6'd23,
    G_W_OP         = 6'd24,
    G_W_LIT        = 6'd25,
    G_D_FROM       = 6'd26,
    G_D_NAME       = 6'd27,
    G_U_NAME       = 6'd28,
    G_U_SET        = 6'd29,
    G_U_COL        = 6'd30,
    G_U_EQ         = 6'd31,
    G_U_VAL        = 6'd32,
    G_U_AFTER      = 6'd33
  } gstate_t;

  typedef struct packed {
    gstate_t          gstate;
    logic [2:0]       cur_stmt;
    logic             column_seen;
    logic [POS_W-1:0] primary_pos;
  } gctx_t;

  typedef struct packed {
    logic [3:0]        token_role;
    logic [2:0]        stmt_kind;
    logic [2:0]        compare_op;
    logic              stmt_done;
    logic              input_done;
    logic              error_flag;
    logic [2:0]        error_code;
    logic [KIND_W-1:0] expected_kind;
    logic [POS_W-1:0]  error_pos;
  } result_t;

endpackage

// ===== sv/sqlck_if.sv =====
interface sqlck_tok_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [15:0] token_pos;

  modport source (output valid, output token_kind, output token_pos, input ready);
  modport sink (input valid, input token_kind, input token_pos, output ready);
endinterface

interface sqlck_res_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_role;
  logic [2:0]  stmt_kind;
  logic [2:0]  compare_op;
  logic        stmt_done;
  logic        input_done;
  logic        error_flag;
  logic [2:0]  error_code;
  logic [4:0]  expected_kind;
  logic [15:0] error_pos;

  modport source (
    output valid, input ready,
    output token_role, output stmt_kind, output compare_op, output stmt_done,
    output input_done, output error_flag, output error_code, output expected_kind,
    output error_pos
  );
  modport sink (
    input valid, output ready,
    input token_role, input stmt_kind, input compare_op, input stmt_done,
    input input_done, input error_flag, input error_code, input expected_kind,
    input error_pos
  );
endinterface

// ===== sv/sqlck_step.sv =====
module sqlck_step
  import sqlck_pkg::*;
(
  input  gctx_t             cur,
  input  logic [KIND_W-1:0] kind,
  input  logic [POS_W-1:0]  pos,
  output gctx_t             nxt,
  output result_t           res
);

  logic              err;
  logic [2:0]        code;
  logic [KIND_W-1:0] need;
  logic              in_stmt;
  logic [3:0]        role;
  logic [2:0]        op;
  logic              done;
  logic              in_done;
  gstate_t           gnext;

  always_comb begin
    nxt     = cur;
    err     = 1'b0;
    code    = E_STMT;
    need    = K_END;
    role    = R_SYNTAX;
    op      = 3'd0;
    done    = 1'b0;
    in_done = 1'b0;
    gnext   = cur.gstate;
    in_stmt = (cur.gstate != G_START);

    unique case (cur.gstate)
      G_SEMI, G_C_RP_SEMI: begin
        if (kind == K_SEMI) begin
          done  = 1'b1;
          gnext = G_START;
        end else begin
          err = 1'b1; code = E_TOKEN; need = K_SEMI;
        end
      end
      G_C_TABLE: begin
        if (kind == K_TABLE) gnext = G_C_NAME;
        else begin err = 1'b1; code = E_TOKEN; need = K_TABLE; end
      end
      G_C_NAME: begin
        if (kind == K_ID) begin gnext = G_C_LP; role = R_TABLE; end
        else begin err = 1'b1; code = E_IDENT; end
      end
      G_C_LP: begin
        if (kind == K_LP) gnext = G_C_COL;
        else begin err = 1'b1; code = E_TOKEN; need = K_LP; end
      end
      G_C_COL: begin
        if (kind == K_ID) begin gnext = G_C_TYPE; role = R_DEF_COL; end
        else begin err = 1'b1; code = E_IDENT; end
      end
      G_C_TYPE: begin
        if (kind == K_ID) begin gnext = G_C_AFTER_TYPE; role = R_TYPE; end
        else begin err = 1'b1; code = E_IDENT; end
      end
      G_C_AFTER_TYPE, G_C_AFTER_KEY: begin
        if (kind == K_PRIMARY && cur.gstate == G_C_AFTER_TYPE) begin
          nxt.primary_pos = pos;
          role            = R_KEY_MARK;
          gnext           = G_C_KEY;
        end else if (kind == K_COMMA) begin
          nxt.column_seen = 1'b1;
          gnext           = G_C_COL;
        end else if (kind == K_RP) begin
          gnext = G_C_RP_SEMI;
        end else begin
          err = 1'b1; code = E_TOKEN; need = K_RP;
        end
      end
      G_C_KEY: begin
        if (kind != K_KEY) begin
          err = 1'b1; code = E_TOKEN; need = K_KEY;
        end else if (cur.column_seen) begin
          err = 1'b1; code = E_KEY_POS;
        end else begin
          role  = R_KEY_MARK;
          gnext = G_C_AFTER_KEY;
        end
      end
      G_I_INTO: begin
        if (kind == K_INTO) gnext = G_I_NAME;
        else begin err = 1'b1; code = E_TOKEN; need = K_INTO; end
      end
      G_I_NAME: begin
        if (kind == K_ID) begin gnext = G_I_VALUES; role = R_TABLE; end
        else begin err = 1'b1; code = E_IDENT; end
      end
      G_I_VALUES: begin
        if (kind == K_VALUES) gnext = G_I_LP;
        else begin err = 1'b1; code = E_TOKEN; need = K_VALUES; end
      end
      G_I_LP: begin
        if (kind == K_LP) gnext = G_I_VAL;
        else begin err = 1'b1; code = E_TOKEN; need = K_LP; end
      end
      G_I_VAL: begin
        if (kind == K_STR || kind == K_NUM) begin gnext = G_I_AFTER; role = R_INS_VAL; end
        else begin err = 1'b1; code = E_LITERAL; end
      end
      G_I_AFTER: begin
        if (kind == K_COMMA) gnext = G_I_VAL;
        else if (kind == K_RP) gnext = G_SEMI;
        else begin err = 1'b1; code = E_TOKEN; need = K_RP; end
      end
      G_S_FIRST: begin
        if (kind == K_STAR) begin
          role  = R_SEL_STAR;
          gnext = G_S_FROM;
        end else if (kind == K_ID) begin
          role  = R_SEL_COL;
          gnext = G_S_AFTER_COL;
        end else begin
          err = 1'b1; code = E_IDENT;
        end
      end
      G_S_AFTER_COL: begin
        if (kind == K_COMMA) gnext = G_S_COL;
        else if (kind == K_FROM) gnext = G_S_TABLE;
        else begin err = 1'b1; code = E_TOKEN; need = K_FROM; end
      end
      G_S_COL: begin
        if (kind == K_ID) begin gnext = G_S_AFTER_COL; role = R_SEL_COL; end
        else begin err = 1'b1; code = E_IDENT; end
      end
      G_S_FROM, G_D_FROM: begin
        if (kind == K_FROM) gnext = (cur.gstate == G_S_FROM) ? G_S_TABLE : G_D_NAME;
        else begin err = 1'b1; code = E_TOKEN; need = K_FROM; end
      end
      G_S_TABLE, G_D_NAME: begin
        if (kind == K_ID) begin gnext = G_W_OPT; role = R_TABLE; end
        else begin err = 1'b1; code = E_IDENT; end
      end
      G_W_OPT: begin
        if (kind == K_WHERE) gnext = G_W_COL;
        else if (kind == K_SEMI) begin done = 1'b1; gnext = G_START; end
        else begin err = 1'b1; code = E_TOKEN; need = K_SEMI; end
      end
      G_W_COL: begin
        if (kind == K_ID) begin gnext = G_W_OP; role = R_WHERE_COL; end
        else begin err = 1'b1; code = E_IDENT; end
      end
      G_W_OP: begin
        if (kind >= K_EQ && kind <= K_GTE) begin
          op    = 3'(kind - K_EQ);
          role  = R_WHERE_OP;
          gnext = G_W_LIT;
        end else begin
          err = 1'b1; code = E_OPER;
        end
      end
      G_W_LIT: begin
        if (kind == K_STR || kind == K_NUM) begin gnext = G_SEMI; role = R_WHERE_LIT; end
        else begin err = 1'b1; code = E_LITERAL; end
      end
      G_U_NAME: begin
        if (kind == K_ID) begin gnext = G_U_SET; role = R_TABLE; end
        else begin err = 1'b1; code = E_IDENT; end
      end
      G_U_SET: begin
        if (kind == K_SET) gnext = G_U_COL;
        else begin err = 1'b1; code = E_TOKEN; need = K_SET; end
      end
      G_U_COL: begin
        if (kind == K_ID) begin gnext = G_U_EQ; role = R_SET_COL; end
        else begin err = 1'b1; code = E_IDENT; end
      end
      G_U_EQ: begin
        if (kind == K_EQ) gnext = G_U_VAL;
        else begin err = 1'b1; code = E_TOKEN; need = K_EQ; end
      end
      G_U_VAL: begin
        if (kind == K_STR || kind == K_NUM) begin gnext = G_U_AFTER; role = R_SET_VAL; end
        else begin err = 1'b1; code = E_LITERAL; end
      end
      G_U_AFTER: begin
        if (kind == K_COMMA) gnext = G_U_COL;
        else if (kind == K_WHERE) gnext = G_W_COL;
        else if (kind == K_SEMI) begin done = 1'b1; gnext = G_START; end
        else begin err = 1'b1; code = E_TOKEN; need = K_SEMI; end
      end
      default: begin
        in_stmt = 1'b0;
        gnext   = G_START;
        unique case (kind)
          K_END:    in_done = 1'b1;
          K_CREATE: begin
            nxt.column_seen = 1'b0;
            nxt.cur_stmt    = ST_CREATE;
            in_stmt         = 1'b1;
            gnext           = G_C_TABLE;
          end
          K_INSERT: begin nxt.cur_stmt = ST_INSERT; in_stmt = 1'b1; gnext = G_I_INTO; end
          K_SELECT: begin nxt.cur_stmt = ST_SELECT; in_stmt = 1'b1; gnext = G_S_FIRST; end
          K_DELETE: begin nxt.cur_stmt = ST_DELETE; in_stmt = 1'b1; gnext = G_D_FROM; end
          K_UPDATE: begin nxt.cur_stmt = ST_UPDATE; in_stmt = 1'b1; gnext = G_U_NAME; end
          K_BEGIN:  begin nxt.cur_stmt = ST_BEGIN; in_stmt = 1'b1; gnext = G_SEMI; end
          K_COMMIT: begin nxt.cur_stmt = ST_COMMIT; in_stmt = 1'b1; gnext = G_SEMI; end
          K_ROLLBACK: begin
            nxt.cur_stmt = ST_ROLLBACK;
            in_stmt      = 1'b1;
            gnext        = G_SEMI;
          end
          default: begin err = 1'b1; code = E_STMT; end
        endcase
      end
    endcase

    if (err) begin
      role  = R_SYNTAX;
      gnext = G_START;
    end
    nxt.gstate = gnext;

    res.token_role    = role;
    res.stmt_kind     = in_stmt ? nxt.cur_stmt : ST_CREATE;
    res.compare_op    = op;
    res.stmt_done     = done;
    res.input_done    = in_done;
    res.error_flag    = err;
    res.error_code    = err ? code : E_STMT;
    res.expected_kind = (err && code == E_TOKEN) ? need : K_END;
    res.error_pos     = !err ? '0 : (code == E_KEY_POS) ? cur.primary_pos : pos;
  end

endmodule

// ===== sv/sql_subset_token_grammar_checker_unit.sv =====
// Token grammar checker for a small SQL subset. Each request on tok carries one lexed
// token (kind code and byte position) and produces exactly one result on res: the
// token's role, the statement kind, the where operator, statement and input completion
// flags, or an error with its code, expected kind and position. A token is registered
// on entry and evaluated by one grammar transition into the result register once that
// register is free, so the block takes one token per cycle while results are taken; a
// result is presented from the result register and held there until it is taken.
// The rate is set by the combinational grammar transition; a stalled result holds both
// registers. After any error the checker resumes at statement start.
module sql_subset_token_grammar_checker_unit
  import sqlck_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  sqlck_tok_if.sink   tok,
  sqlck_res_if.source res
);

  logic              in_v;
  logic [KIND_W-1:0] in_kind;
  logic [POS_W-1:0]  in_pos;
  logic              step_fire;
  gctx_t             ctx;
  gctx_t             ctx_next;
  result_t           step_res;
  result_t           out_res;
  logic              out_v;

  assign step_fire = in_v && (!out_v || res.ready);
  assign tok.ready = !in_v || step_fire;

  sqlck_step u_step (
    .cur  (ctx),
    .kind (in_kind),
    .pos  (in_pos),
    .nxt  (ctx_next),
    .res  (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (tok.ready) begin
      in_v <= tok.valid;
    end
    if (tok.ready && tok.valid) begin
      in_kind <= tok.token_kind;
      in_pos  <= tok.token_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctx.gstate      <= G_START;
      ctx.cur_stmt    <= ST_CREATE;
      ctx.column_seen <= 1'b0;
      ctx.primary_pos <= '0;
      out_v           <= 1'b0;
    end else begin
      if (step_fire) begin
        ctx   <= ctx_next;
        out_v <= 1'b1;
      end else if (res.ready) begin
        out_v <= 1'b0;
      end
    end
    if (step_fire) begin
      out_res <= step_res;
    end
  end

  assign res.valid         = out_v;
  assign res.token_role    = out_res.token_role;
  assign res.stmt_kind     = out_res.stmt_kind;
  assign res.compare_op    = out_res.compare_op;
  assign res.stmt_done     = out_res.stmt_done;
  assign res.input_done    = out_res.input_done;
  assign res.error_flag    = out_res.error_flag;
  assign res.error_code    = out_res.error_code;
  assign res.expected_kind = out_res.expected_kind;
  assign res.error_pos     = out_res.error_pos;

  a_err_restart: assert property (@(posedge clk) disable iff (rst)
    step_fire && step_res.error_flag |=> ctx.gstate == G_START)
    else $error("Grammar state did not return to statement start after an error.");

  a_err_no_role: assert property (@(posedge clk) disable iff (rst)
    out_v && out_res.error_flag |-> out_res.token_role == R_SYNTAX && !out_res.stmt_done)
    else $error("An error result carries a role or a completion flag.");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !tok.ready |-> in_v && out_v && !res.ready)
    else $error("Token request refused without a full pipeline.");

  a_exp_kind: assert property (@(posedge clk) disable iff (rst)
    out_v && out_res.error_flag && out_res.error_code == E_TOKEN
      |-> out_res.expected_kind != K_END)
    else $error("Specific token error without an expected kind.");

endmodule

// ===== tb/sv/tb_sql_subset_token_grammar_checker_unit.sv =====
`timescale 1ns / 1ps

module tb_sql_subset_token_grammar_checker_unit;
  import sqlck_pkg::*;

  localparam logic [KIND_W-1:0] K_UNUSED = 5'd31;
  localparam logic [2:0] OP_EQ = 3'd0;
  localparam int IDLE_LIMIT = 1000;
  localparam int RANDOM_TOKENS = 1700;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  pos;
    logic              fixed;
    result_t           fixed_res;
  } token_req_t;

  localparam result_t NO_RESULT = '0;

  logic clk = 1'b0;
  logic rst;

  sqlck_tok_if tok ();
  sqlck_res_if res ();

  sql_subset_token_grammar_checker_unit dut (
    .clk (clk),
    .rst (rst),
    .tok (tok),
    .res (res)
  );

  always #5 clk = ~clk;

  token_req_t directed [26];
  token_req_t feed [$];
  logic [KIND_W-1:0] stmt_toks [$];
  result_t outcome_q [$];

  gstate_t          g_state = G_START;
  logic [2:0]       cur_stmt = ST_CREATE;
  logic             col_seen = 1'b0;
  logic [POS_W-1:0] mark_pos = '0;

  int send_idx = 0;
  int acc_idx = 0;
  int burst_left = 1;
  int gap_left = 0;
  int rdy_phase = 0;
  int rdy_mode = 0;
  int idle_cycles = 0;
  int fail_cnt = 0;
  int n_res = 0;
  int n_done = 0;
  int n_err = 0;
  int n_end = 0;

  function automatic result_t grammar_step(input logic [KIND_W-1:0] kind,
                                           input logic [POS_W-1:0] pos);
    result_t r;
    gstate_t nxt;
    logic in_stmt;
    logic bad;
    logic [2:0] code;
    logic [KIND_W-1:0] need;
    logic [POS_W-1:0] epos;
    r = NO_RESULT;
    nxt = g_state;
    in_stmt = (g_state != G_START);
    bad = 1'b0;
    code = E_STMT;
    need = K_END;
    epos = pos;
    case (g_state)
      G_SEMI, G_C_RP_SEMI: begin
        if (kind == K_SEMI) begin
          r.stmt_done = 1'b1;
          nxt = G_START;
        end else {bad, code, need} = {1'b1, E_TOKEN, K_SEMI};
      end
      G_C_TABLE: begin
        if (kind == K_TABLE) nxt = G_C_NAME;
        else {bad, code, need} = {1'b1, E_TOKEN, K_TABLE};
      end
      G_C_NAME, G_I_NAME, G_U_NAME, G_S_TABLE, G_D_NAME: begin
        if (kind == K_ID) begin
          r.token_role = R_TABLE;
          case (g_state)
            G_C_NAME: nxt = G_C_LP;
            G_I_NAME: nxt = G_I_VALUES;
            G_U_NAME: nxt = G_U_SET;
            default:  nxt = G_W_OPT;
          endcase
        end else {bad, code} = {1'b1, E_IDENT};
      end
      G_C_LP, G_I_LP: begin
        if (kind == K_LP) nxt = (g_state == G_C_LP) ? G_C_COL : G_I_VAL;
        else {bad, code, need} = {1'b1, E_TOKEN, K_LP};
      end
      G_C_COL: begin
        if (kind == K_ID) begin
          r.token_role = R_DEF_COL;
          nxt = G_C_TYPE;
        end else {bad, code} = {1'b1, E_IDENT};
      end
      G_C_TYPE: begin
        if (kind == K_ID) begin
          r.token_role = R_TYPE;
          nxt = G_C_AFTER_TYPE;
        end else {bad, code} = {1'b1, E_IDENT};
      end
      G_C_AFTER_TYPE, G_C_AFTER_KEY: begin
        if (g_state == G_C_AFTER_TYPE && kind == K_PRIMARY) begin
          mark_pos = pos;
          r.token_role = R_KEY_MARK;
          nxt = G_C_KEY;
        end else if (kind == K_COMMA) begin
          col_seen = 1'b1;
          nxt = G_C_COL;
        end else if (kind == K_RP) nxt = G_C_RP_SEMI;
        else {bad, code, need} = {1'b1, E_TOKEN, K_RP};
      end
      G_C_KEY: begin
        if (kind != K_KEY) {bad, code, need} = {1'b1, E_TOKEN, K_KEY};
        else if (col_seen) begin
          {bad, code} = {1'b1, E_KEY_POS};
          epos = mark_pos;
        end else begin
          r.token_role = R_KEY_MARK;
          nxt = G_C_AFTER_KEY;
        end
      end
      G_I_INTO: begin
        if (kind == K_INTO) nxt = G_I_NAME;
        else {bad, code, need} = {1'b1, E_TOKEN, K_INTO};
      end
      G_I_VALUES: begin
        if (kind == K_VALUES) nxt = G_I_LP;
        else {bad, code, need} = {1'b1, E_TOKEN, K_VALUES};
      end
      G_I_VAL, G_U_VAL, G_W_LIT: begin
        if (kind == K_STR || kind == K_NUM) begin
          case (g_state)
            G_I_VAL: begin r.token_role = R_INS_VAL; nxt = G_I_AFTER; end
            G_U_VAL: begin r.token_role = R_SET_VAL; nxt = G_U_AFTER; end
            default: begin r.token_role = R_WHERE_LIT; nxt = G_SEMI; end
          endcase
        end else {bad, code} = {1'b1, E_LITERAL};
      end
      G_I_AFTER: begin
        if (kind == K_COMMA) nxt = G_I_VAL;
        else if (kind == K_RP) nxt = G_SEMI;
        else {bad, code, need} = {1'b1, E_TOKEN, K_RP};
      end
      G_S_FIRST, G_S_COL: begin
        if (g_state == G_S_FIRST && kind == K_STAR) begin
          r.token_role = R_SEL_STAR;
          nxt = G_S_FROM;
        end else if (kind == K_ID) begin
          r.token_role = R_SEL_COL;
          nxt = G_S_AFTER_COL;
        end else {bad, code} = {1'b1, E_IDENT};
      end
      G_S_AFTER_COL: begin
        if (kind == K_COMMA) nxt = G_S_COL;
        else if (kind == K_FROM) nxt = G_S_TABLE;
        else {bad, code, need} = {1'b1, E_TOKEN, K_FROM};
      end
      G_S_FROM, G_D_FROM: begin
        if (kind == K_FROM) nxt = (g_state == G_S_FROM) ? G_S_TABLE : G_D_NAME;
        else {bad, code, need} = {1'b1, E_TOKEN, K_FROM};
      end
      G_W_OPT, G_U_AFTER: begin
        if (g_state == G_U_AFTER && kind == K_COMMA) nxt = G_U_COL;
        else if (kind == K_WHERE) nxt = G_W_COL;
        else if (kind == K_SEMI) begin
          r.stmt_done = 1'b1;
          nxt = G_START;
        end else {bad, code, need} = {1'b1, E_TOKEN, K_SEMI};
      end
      G_W_COL: begin
        if (kind == K_ID) begin
          r.token_role = R_WHERE_COL;
          nxt = G_W_OP;
        end else {bad, code} = {1'b1, E_IDENT};
      end
      G_W_OP: begin
        if (kind >= K_EQ && kind <= K_GTE) begin
          r.compare_op = 3'(kind - K_EQ);
          r.token_role = R_WHERE_OP;
          nxt = G_W_LIT;
        end else {bad, code} = {1'b1, E_OPER};
      end
      G_U_SET: begin
        if (kind == K_SET) nxt = G_U_COL;
        else {bad, code, need} = {1'b1, E_TOKEN, K_SET};
      end
      G_U_COL: begin
        if (kind == K_ID) begin
          r.token_role = R_SET_COL;
          nxt = G_U_EQ;
        end else {bad, code} = {1'b1, E_IDENT};
      end
      G_U_EQ: begin
        if (kind == K_EQ) nxt = G_U_VAL;
        else {bad, code, need} = {1'b1, E_TOKEN, K_EQ};
      end
      default: begin
        nxt = G_START;
        case (kind)
          K_END:      r.input_done = 1'b1;
          K_CREATE:   begin col_seen = 1'b0; cur_stmt = ST_CREATE; nxt = G_C_TABLE; end
          K_INSERT:   begin cur_stmt = ST_INSERT; nxt = G_I_INTO; end
          K_SELECT:   begin cur_stmt = ST_SELECT; nxt = G_S_FIRST; end
          K_DELETE:   begin cur_stmt = ST_DELETE; nxt = G_D_FROM; end
          K_UPDATE:   begin cur_stmt = ST_UPDATE; nxt = G_U_NAME; end
          K_BEGIN:    begin cur_stmt = ST_BEGIN; nxt = G_SEMI; end
          K_COMMIT:   begin cur_stmt = ST_COMMIT; nxt = G_SEMI; end
          K_ROLLBACK: begin cur_stmt = ST_ROLLBACK; nxt = G_SEMI; end
          default:    {bad, code} = {1'b1, E_STMT};
        endcase
        if (nxt != G_START) in_stmt = 1'b1;
      end
    endcase
    if (bad) begin
      r.token_role = R_SYNTAX;
      r.error_flag = 1'b1;
      r.error_code = code;
      r.expected_kind = (code == E_TOKEN) ? need : K_END;
      r.error_pos = epos;
      nxt = G_START;
    end
    r.stmt_kind = in_stmt ? cur_stmt : ST_CREATE;
    g_state = nxt;
    return r;
  endfunction

  task automatic put(input logic [KIND_W-1:0] kind);
    stmt_toks.insert(stmt_toks.size(), kind);
  endtask

  function automatic logic [KIND_W-1:0] lit_kind();
    return $urandom_range(0, 1) ? K_STR : K_NUM;
  endfunction

  task automatic put_where();
    if ($urandom_range(0, 1)) begin
      put(K_WHERE);
      put(K_ID);
      put(5'($urandom_range(K_EQ, K_GTE)));
      put(lit_kind());
    end
  endtask

  task automatic gen_statement();
    int n;
    int pick;
    int mangle;
    int at;
    logic [POS_W-1:0] pos;
    token_req_t req;
    stmt_toks.delete();
    pick = $urandom_range(0, 19);
    case (pick)
      0, 1, 2: begin
        n = $urandom_range(1, 4);
        put(K_CREATE); put(K_TABLE); put(K_ID); put(K_LP);
        for (int i = 0; i < n; i++) begin
          if (i > 0) put(K_COMMA);
          put(K_ID); put(K_ID);
          if ((i == 0 && $urandom_range(0, 1)) || (i > 0 && $urandom_range(0, 7) == 0)) begin
            put(K_PRIMARY); put(K_KEY);
          end
        end
        put(K_RP); put(K_SEMI);
      end
      3, 4, 5: begin
        n = $urandom_range(1, 4);
        put(K_INSERT); put(K_INTO); put(K_ID); put(K_VALUES); put(K_LP);
        for (int i = 0; i < n; i++) begin
          if (i > 0) put(K_COMMA);
          put(lit_kind());
        end
        put(K_RP); put(K_SEMI);
      end
      6, 7, 8: begin
        put(K_SELECT);
        if ($urandom_range(0, 2) == 0) put(K_STAR);
        else begin
          n = $urandom_range(1, 3);
          for (int i = 0; i < n; i++) begin
            if (i > 0) put(K_COMMA);
            put(K_ID);
          end
        end
        put(K_FROM); put(K_ID);
        put_where();
        put(K_SEMI);
      end
      9, 10: begin
        put(K_DELETE); put(K_FROM); put(K_ID);
        put_where();
        put(K_SEMI);
      end
      11, 12, 13: begin
        n = $urandom_range(1, 3);
        put(K_UPDATE); put(K_ID); put(K_SET);
        for (int i = 0; i < n; i++) begin
          if (i > 0) put(K_COMMA);
          put(K_ID); put(K_EQ); put(lit_kind());
        end
        put_where();
        put(K_SEMI);
      end
      14, 15: begin
        case ($urandom_range(0, 2))
          0:       put(K_BEGIN);
          1:       put(K_COMMIT);
          default: put(K_ROLLBACK);
        endcase
        put(K_SEMI);
      end
      16, 17: begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) put(5'($urandom_range(0, 31)));
      end
      default: put(K_END);
    endcase
    mangle = $urandom_range(0, 11);
    at = $urandom_range(0, stmt_toks.size() - 1);
    if (mangle == 0) stmt_toks[at] = 5'($urandom_range(0, 31));
    else if (mangle == 1) stmt_toks[at] = K_END;
    else if (mangle == 2) begin
      while (stmt_toks.size() > at + 1) void'(stmt_toks.pop_back());
    end
    foreach (stmt_toks[i]) begin
      if ($urandom_range(0, 7) == 0) pos = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      else pos = 16'($urandom_range(0, 65535));
      req = '{stmt_toks[i], pos, 1'b0, NO_RESULT};
      feed.insert(feed.size(), req);
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      if (fail_cnt < 50)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      tok.valid <= 1'b0;
      burst_left <= 1;
      gap_left <= 0;
    end else if (!tok.valid || tok.ready) begin
      if (gap_left > 0 || send_idx >= feed.size()) begin
        tok.valid <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        tok.valid <= 1'b1;
        tok.token_kind <= feed[send_idx].kind;
        tok.token_pos <= feed[send_idx].pos;
        send_idx <= send_idx + 1;
        if (burst_left > 1) burst_left <= burst_left - 1;
        else begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
      rdy_phase <= 0;
      rdy_mode <= 0;
    end else begin
      if (rdy_phase == 0) begin
        rdy_mode <= $urandom_range(0, 3);
        rdy_phase <= $urandom_range(4, 40);
      end else rdy_phase <= rdy_phase - 1;
      case (rdy_mode)
        0:       res.ready <= 1'b1;
        1:       res.ready <= ($urandom_range(0, 3) != 0);
        2:       res.ready <= ~res.ready;
        default: res.ready <= ($urandom_range(0, 15) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    token_req_t item;
    result_t pred;
    result_t want;
    if (!rst) begin
      if (tok.valid && tok.ready) begin
        item = feed[acc_idx];
        acc_idx++;
        pred = grammar_step(tok.token_kind, tok.token_pos);
        outcome_q.insert(outcome_q.size(), item.fixed ? item.fixed_res : pred);
      end
      if (res.valid && res.ready) begin
        n_res++;
        n_done += int'(res.stmt_done);
        n_err += int'(res.error_flag);
        n_end += int'(res.input_done);
        if (outcome_q.size() == 0) begin
          $display("%0t: result with no pending request, got role %0h error %0b", $time,
                   res.token_role, res.error_flag);
          fail_cnt++;
        end else begin
          want = outcome_q.pop_front();
          check_field("token_role", 16'(want.token_role), 16'(res.token_role));
          check_field("stmt_kind", 16'(want.stmt_kind), 16'(res.stmt_kind));
          check_field("compare_op", 16'(want.compare_op), 16'(res.compare_op));
          check_field("stmt_done", 16'(want.stmt_done), 16'(res.stmt_done));
          check_field("input_done", 16'(want.input_done), 16'(res.input_done));
          check_field("error_flag", 16'(want.error_flag), 16'(res.error_flag));
          check_field("error_code", 16'(want.error_code), 16'(res.error_code));
          check_field("expected_kind", 16'(want.expected_kind), 16'(res.expected_kind));
          check_field("error_pos", want.error_pos, res.error_pos);
        end
      end
      if ((tok.valid && tok.ready) || (res.valid && res.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles, %0d requests still pending", $time,
                 IDLE_LIMIT, outcome_q.size());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    tok.valid = 1'b0;
    tok.token_kind = K_END;
    tok.token_pos = '0;
    res.ready = 1'b0;

    // Fields of a fixed result: role, statement, operator, done, input done, error flag,
    // error code, expected kind, error position.
    directed = '{
      '{K_END,      16'h0000, 1'b1,
        '{R_SYNTAX, ST_CREATE, OP_EQ, 1'b0, 1'b1, 1'b0, E_STMT, K_END, 16'h0000}},
      '{K_UNUSED,   16'hFFFF, 1'b1,
        '{R_SYNTAX, ST_CREATE, OP_EQ, 1'b0, 1'b0, 1'b1, E_STMT, K_END, 16'hFFFF}},
      '{K_ROLLBACK, 16'h0001, 1'b0, NO_RESULT},
      '{K_END,      16'h0002, 1'b1,
        '{R_SYNTAX, ST_ROLLBACK, OP_EQ, 1'b0, 1'b0, 1'b1, E_TOKEN, K_SEMI, 16'h0002}},
      '{K_CREATE,   16'h0010, 1'b0, NO_RESULT},
      '{K_TABLE,    16'h0011, 1'b0, NO_RESULT},
      '{K_ID,       16'h0012, 1'b0, NO_RESULT},
      '{K_LP,       16'h0013, 1'b0, NO_RESULT},
      '{K_ID,       16'h0014, 1'b0, NO_RESULT},
      '{K_ID,       16'h0015, 1'b0, NO_RESULT},
      '{K_PRIMARY,  16'h1234, 1'b0, NO_RESULT},
      '{K_KEY,      16'h1235, 1'b0, NO_RESULT},
      '{K_COMMA,    16'h0016, 1'b0, NO_RESULT},
      '{K_ID,       16'h0017, 1'b0, NO_RESULT},
      '{K_ID,       16'h0018, 1'b0, NO_RESULT},
      '{K_PRIMARY,  16'hABCD, 1'b0, NO_RESULT},
      '{K_KEY,      16'h8000, 1'b1,
        '{R_SYNTAX, ST_CREATE, OP_EQ, 1'b0, 1'b0, 1'b1, E_KEY_POS, K_END, 16'hABCD}},
      '{K_SELECT,   16'h0020, 1'b0, NO_RESULT},
      '{K_STAR,     16'h0021, 1'b0, NO_RESULT},
      '{K_FROM,     16'h0022, 1'b0, NO_RESULT},
      '{K_ID,       16'h0023, 1'b0, NO_RESULT},
      '{K_WHERE,    16'h0024, 1'b0, NO_RESULT},
      '{K_ID,       16'h0025, 1'b0, NO_RESULT},
      '{K_GTE,      16'h7FFF, 1'b0, NO_RESULT},
      '{K_NUM,      16'h5555, 1'b0, NO_RESULT},
      '{K_SEMI,     16'hAAAA, 1'b1,
        '{R_SYNTAX, ST_SELECT, OP_EQ, 1'b1, 1'b0, 1'b0, E_STMT, K_END, 16'h0000}}
    };
    foreach (directed[i]) feed.insert(feed.size(), directed[i]);
    while (feed.size() < $size(directed) + RANDOM_TOKENS) gen_statement();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (acc_idx < feed.size()) @(posedge clk);
    while (outcome_q.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Ran %0d tokens through the grammar and checked %0d results.", feed.size(), n_res);
    $display("Seen: %0d completed statements, %0d syntax errors, %0d end-of-input marks.",
             n_done, n_err, n_end);
    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/sqlck_pkg.sv
sv/sqlck_if.sv
sv/sqlck_step.sv
sv/sql_subset_token_grammar_checker_unit.sv
tb/sv/tb_sql_subset_token_grammar_checker_unit.sv
